FILE: sv/mbps_pkg.sv
package mbps_pkg;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_NEW  = 2'd2;

  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_FIND_ALL       = 1'b1;

  localparam int CFG_DATA_W = 7;
  localparam logic [6:0] FILL_MAX = 7'd127;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] entry_index;
    logic [7:0] entry_value;
    logic [7:0] entry_ignore;
    logic [7:0] data_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
    logic        scan_done;
  } result_t;

endpackage

FILE: sv/mbps_pattern.sv
module mbps_pattern
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  parameter int NW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [5:0]               index,
  input  logic [7:0]               value,
  input  logic [7:0]               ignore,
  input  logic [NW-1:0]            shamt,
  output logic [8*MAX_PATTERN-1:0] value_al,
  output logic [8*MAX_PATTERN-1:0] care_al
);

  logic [7:0] value_q [MAX_PATTERN];
  logic [7:0] care_q  [MAX_PATTERN];
  logic [8*MAX_PATTERN-1:0] value_rev;
  logic [8*MAX_PATTERN-1:0] care_rev;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (we && 32'(index) == k) begin
        value_q[k] <= value;
        care_q[k]  <= ~ignore;
      end
    end
    assign value_rev[8*(MAX_PATTERN-1-k) +: 8] = value_q[k];
    assign care_rev[8*(MAX_PATTERN-1-k) +: 8]  = care_q[k];
  end

  // slot j now holds entry length-1-j; slots past the length read as wildcards
  assign value_al = value_rev >> {shamt, 3'b000};
  assign care_al  = care_rev >> {shamt, 3'b000};

endmodule

FILE: sv/mbps_scan.sv
module mbps_scan
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  parameter int NW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  item_t                    item,
  input  logic [NW-1:0]            neff,
  input  logic                     find_all,
  input  logic [8*MAX_PATTERN-1:0] value_al,
  input  logic [8*MAX_PATTERN-1:0] care_al,
  output result_t                  res
);

  localparam int WINW = 8 * MAX_PATTERN;
  localparam int CW = (NW > 7) ? NW : 7;

  logic [WINW-1:0]        window;
  logic [WINW-1:0]        window_next;
  logic [6:0]             fill;
  logic [6:0]             fill_next;
  logic [6:0]             fill_inc;
  logic [31:0]            offset;
  logic [31:0]            offset_next;
  logic                   stopped;
  logic                   stopped_next;
  logic [MAX_PATTERN-1:0] pos_ok;
  logic                   hit;

  assign window_next = WINW'({window, item.data_byte});
  assign fill_inc    = (fill == FILL_MAX) ? fill : fill + 7'd1;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pos_ok[j] = (care_al[8*j +: 8] == 8'd0) ||
                  ((window_next[8*j +: 8] & care_al[8*j +: 8]) == value_al[8*j +: 8]);
    end
  end

  assign hit = (CW'(fill_inc) >= CW'(neff)) && (&pos_ok);

  always_comb begin
    res          = '0;
    fill_next    = fill;
    offset_next  = offset;
    stopped_next = stopped;
    case (item.mode)
      MODE_NEW: begin
        fill_next    = 7'd0;
        offset_next  = 32'd0;
        stopped_next = 1'b0;
      end
      MODE_DATA: begin
        offset_next = offset + 32'd1;
        if (stopped) begin
          res.scan_done = 1'b1;
        end else begin
          fill_next = fill_inc;
          if (hit) begin
            res.match_found  = 1'b1;
            res.match_offset = offset - 32'(neff) + 32'd1;
            fill_next        = 7'd0;
            if (!find_all) stopped_next = 1'b1;
          end
          if (item.final_byte) stopped_next = 1'b1;
          res.scan_done = stopped_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= 7'd0;
      offset  <= 32'd0;
      stopped <= 1'b0;
    end else if (en) begin
      fill    <= fill_next;
      offset  <= offset_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && item.mode == MODE_DATA && !stopped) begin
      window <= window_next;
    end
  end

endmodule

FILE: sv/masked_byte_pattern_search.sv
// Masked byte pattern search.
// Words enter on the s_ group; s_tuser carries the mode: load a pattern
// entry, a data byte, or start a new buffer. s_tlast marks the final data
// byte of a buffer. Every input word yields exactly one word on the m_
// group: m_tuser is the match flag, m_tdata the match start offset (zero
// without a match) and m_tlast says the scan of the buffer is over.
// A data byte matches when the last pattern_length bytes agree with the
// pattern entries under their ignore masks; an ignore of all ones is a
// full wildcard. After a match the window refills before the next one.
// pattern_length and find_all are written on the cfg_ port while idle.
// A word passes the input register, then the result register; one word per
// cycle is sustained while m_tready is high, set by the single window
// compare between the two. A stalled m_ side holds its word while the
// input register still takes one more word, then s_tready drops.
// Reset clears the handshake, the offset, the fill count and the stop flag
// and sets pattern_length and find_all to 1; pattern entries must be
// loaded before they are used.
module masked_byte_pattern_search
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_index[5:0], entry_value[13:6], entry_ignore[21:14], data_byte[29:22], zero
  input  logic [31:0]           s_tdata,
  // mode[1:0]
  input  logic [1:0]            s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // match_offset[31:0]
  output logic [31:0]           m_tdata,
  // match_found[0]
  output logic                  m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NW = $clog2(MAX_PATTERN + 1);
  localparam int CW = (NW > 7) ? NW : 7;

  logic [6:0]               pattern_length;
  logic                     find_all;
  item_t                    in_q;
  logic                     in_valid;
  result_t                  res_q;
  result_t                  res_next;
  logic                     res_valid;
  logic                     adv_out;
  logic                     proc;
  logic [CW-1:0]            len_ext;
  logic [CW-1:0]            neff_c;
  logic [NW-1:0]            neff;
  logic [NW-1:0]            shamt;
  logic [8*MAX_PATTERN-1:0] value_al;
  logic [8*MAX_PATTERN-1:0] care_al;
  logic                     pat_we;

  assign adv_out  = !res_valid || m_tready;
  assign proc     = in_valid && adv_out;
  assign s_tready = !in_valid || adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= 7'd1;
      find_all       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data;
        REG_FIND_ALL:       find_all       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (proc) begin
        in_valid <= 1'b0;
      end
      if (adv_out) res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q.mode         <= s_tuser;
      in_q.entry_index  <= s_tdata[5:0];
      in_q.entry_value  <= s_tdata[13:6];
      in_q.entry_ignore <= s_tdata[21:14];
      in_q.data_byte    <= s_tdata[29:22];
      in_q.final_byte   <= s_tlast;
    end
    if (proc) res_q <= res_next;
  end

  assign len_ext = CW'(pattern_length);
  assign neff_c  = (pattern_length == 7'd0) ? CW'(1) :
                   ((len_ext > CW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : len_ext);
  assign neff    = NW'(neff_c);
  assign shamt   = NW'(MAX_PATTERN) - neff;
  assign pat_we  = proc && in_q.mode == MODE_LOAD && 32'(in_q.entry_index) < MAX_PATTERN;

  mbps_pattern #(
    .MAX_PATTERN(MAX_PATTERN),
    .NW(NW)
  ) u_pattern (
    .clk(clk),
    .we(pat_we),
    .index(in_q.entry_index),
    .value(in_q.entry_value),
    .ignore(in_q.entry_ignore),
    .shamt(shamt),
    .value_al(value_al),
    .care_al(care_al)
  );

  mbps_scan #(
    .MAX_PATTERN(MAX_PATTERN),
    .NW(NW)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .en(proc),
    .item(in_q),
    .neff(neff),
    .find_all(find_all),
    .value_al(value_al),
    .care_al(care_al),
    .res(res_next)
  );

  assign m_tvalid = res_valid;
  assign m_tdata  = res_q.match_offset;
  assign m_tuser  = res_q.match_found;
  assign m_tlast  = res_q.scan_done;

  a_stop_after_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && !find_all |-> m_tlast)
    else $error("match with find_all clear did not end the scan");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("offset set without a match");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while both stages are full");

endmodule
